FILE: rtl/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types and constants for the paged ring read request planner.
// ----------------------------------------------------------------------------
package prp_pkg;

    localparam int MAX_BLOCKS = 256;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_W     = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = 48;
    localparam int RING_W     = 31;
    localparam int MAX_OUT    = 64;
    localparam int CNT_W      = $clog2(MAX_OUT + 1);
    localparam int DIV_STEPS  = ADDR_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] CFG_RECS_PER_BLOCK = 2'd0;
    localparam logic [1:0] CFG_RECORD_BYTES   = 2'd1;
    localparam logic [1:0] CFG_MAX_REQ_RECS   = 2'd2;
    localparam logic [1:0] CFG_RING_BYTES     = 2'd3;

    typedef struct packed {
        logic                 restart;
        logic [BLK_W-1:0]     target_block;
        logic [15:0]          record_total;
    } t_in_item;

    typedef struct packed {
        logic [BLK_W-1:0]     request_block;
        logic [23:0]          seek_record;
        logic [15:0]          request_records;
        logic [ADDR_W-1:0]    page_start;
        logic [ADDR_W-1:0]    data_start;
        logic [ADDR_W-1:0]    data_end;
        logic [ADDR_W-1:0]    page_end;
        logic                 final_request;
        logic                 overflow;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic rd_mem;
        logic take_off;
        logic mult;
        logic mod_start;
        logic mod_take;
        logic cap_start;
        logic cap_take;
        logic cap_clear;
        logic skip;
        logic cap_fix;
        logic calc1;
        logic calc2;
        logic calc3;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic left_zero;
        logic room_pos;
        logic cap_zero;
        logic retried;
        logic out_free;
        logic last;
    } t_sts;

endpackage

FILE: rtl/prp_div.sv
// ----------------------------------------------------------------------------
// prp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [prp_pkg::ADDR_W-1:0]    i_dividend,
    input  logic [prp_pkg::RING_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [prp_pkg::ADDR_W-1:0]    o_quot,
    output logic [prp_pkg::RING_W-1:0]    o_rem
);

    logic [prp_pkg::RING_W-1:0]    r_rem, n_rem;
    logic [prp_pkg::ADDR_W-1:0]    r_quo, n_quo;
    logic [prp_pkg::RING_W-1:0]    r_dvs;
    logic [prp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy, r_done;
    logic [prp_pkg::RING_W:0]      w_trial;
    logic [prp_pkg::RING_W:0]      w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[prp_pkg::ADDR_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        if (!w_diff[prp_pkg::RING_W]) begin
            n_rem = w_diff[prp_pkg::RING_W-1:0];
            n_quo = {r_quo[prp_pkg::ADDR_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial[prp_pkg::RING_W-1:0];
            n_quo = {r_quo[prp_pkg::ADDR_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= prp_pkg::DIV_CNT_W'(prp_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == prp_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/prp_datapath.sv
// ----------------------------------------------------------------------------
// prp_datapath
// Config registers, per-block offset store, ring state, request arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module prp_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  prp_pkg::t_cmd         i_cmd,
    output prp_pkg::t_sts         o_sts,
    input  prp_pkg::t_in_item     i_in_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output prp_pkg::t_out_item    o_out_data
);

    localparam int AW = prp_pkg::ADDR_W;
    localparam int PW = prp_pkg::PAGE_W;
    localparam int RW = prp_pkg::RING_W;

    // config
    logic [15:0]   r_rpb, r_rb, r_lim;
    logic [RW-1:0] r_ring;
    logic [15:0]   w_rb, w_lim;
    logic [RW-1:0] w_wrap;

    // offset store
    logic [15:0]                    r_mem [prp_pkg::MAX_BLOCKS];
    logic [prp_pkg::MAX_BLOCKS-1:0] r_vld;
    logic [15:0]                    r_mem_q;
    logic                           r_mem_v;

    // item and ring state
    logic [prp_pkg::BLK_W-1:0] r_blk;
    logic [15:0]               r_left, r_off, r_n;
    logic [prp_pkg::CNT_W-1:0] r_cnt;
    logic [AW-1:0]             r_pos, r_pstart, r_dstart, r_dend;
    logic [PW:0]               r_tail;
    logic [RW-1:0]             r_posmod, r_cap;
    logic [PW-1:0]             r_hb;
    logic [23:0]               r_seek;
    logic [31:0]               r_prod;
    logic                      r_retry;

    logic                  r_ovalid;
    prp_pkg::t_out_item    r_out;

    // divider
    logic          w_div_start, w_div_done;
    logic [AW-1:0] w_div_a, w_div_q;
    logic [RW-1:0] w_div_b, w_div_r;

    logic signed [RW+1:0] w_room;
    logic                 w_room_pos;
    logic [PW-1:0]        w_head;
    logic [PW+1:0]        w_share;
    logic                 w_bump;
    logic [15:0]          w_n1, w_n;
    logic [AW-1:0]        w_dm1, w_pend;
    logic [PW:0]          w_tail;
    logic [15:0]          w_left_nx;
    logic [prp_pkg::CNT_W-1:0] w_cnt_nx;
    logic                 w_last, w_ovf;

    assign w_rb   = (r_rb == '0) ? 16'd1 : r_rb;
    assign w_lim  = (r_lim == '0) ? 16'd1 : r_lim;
    assign w_wrap = (r_ring == '0) ? RW'(1) : r_ring;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpb  <= 16'd1024;
            r_rb   <= 16'd64;
            r_lim  <= 16'd256;
            r_ring <= RW'(1048576);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                prp_pkg::CFG_RECS_PER_BLOCK: r_rpb  <= i_cfg_data[15:0];
                prp_pkg::CFG_RECORD_BYTES:   r_rb   <= i_cfg_data[15:0];
                prp_pkg::CFG_MAX_REQ_RECS:   r_lim  <= i_cfg_data[15:0];
                prp_pkg::CFG_RING_BYTES:     r_ring <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // room before the wrap boundary, signed
    assign w_room = $signed({2'b00, w_wrap}) - $signed({2'b00, r_posmod})
                  - $signed({{(RW+2-PW){1'b0}}, r_hb});
    assign w_room_pos = !w_room[RW+1] && (w_room != '0);

    assign w_div_start = i_cmd.mod_start || i_cmd.cap_start;
    assign w_div_a = i_cmd.cap_start ? {{(AW-RW){1'b0}}, w_room[RW-1:0]} : r_pos;
    assign w_div_b = i_cmd.cap_start ? {{(RW-16){1'b0}}, w_rb} : w_wrap;

    prp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div_done),
        .o_quot     (w_div_q),
        .o_rem      (w_div_r)
    );

    // request sizing and placement
    assign w_head  = PW'(0) - r_hb;
    assign w_share = {1'b0, r_tail} + {2'b00, w_head};
    assign w_bump  = (w_share > (PW+2)'(prp_pkg::PAGE_BYTES))
                  || ((r_posmod == '0) && (w_head != '0));
    assign w_n1    = (r_cap > {{(RW-16){1'b0}}, w_lim}) ? w_lim : r_cap[15:0];
    assign w_n     = (r_left < w_n1) ? r_left : w_n1;

    // tail fragment and next page boundary
    assign w_dm1  = r_dend - AW'(1);
    assign w_tail = (r_dend == '0) ? '0 : ({1'b0, w_dm1[PW-1:0]} + (PW+1)'(1));
    assign w_pend = (r_dend == '0) ? AW'(prp_pkg::PAGE_BYTES)
                  : {w_dm1[AW-1:PW] + (AW-PW)'(1), {PW{1'b0}}};

    assign w_left_nx = r_left - r_n;
    assign w_cnt_nx  = r_cnt + 1'b1;
    assign w_ovf     = (w_left_nx != '0) && (w_cnt_nx == prp_pkg::CNT_W'(prp_pkg::MAX_OUT));
    assign w_last    = (w_left_nx == '0) || w_ovf;

    // offset store: valid bits clear on reset and restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.accept && i_in_data.restart) begin
            r_vld <= '0;
        end else if (i_cmd.emit) begin
            r_vld[r_blk] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_mem[r_blk] <= r_off + r_n;
        end
        if (i_cmd.rd_mem) begin
            r_mem_q <= r_mem[r_blk];
            r_mem_v <= r_vld[r_blk];
        end
    end

    // ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_tail <= '0;
        end else if (i_cmd.accept && i_in_data.restart) begin
            r_pos  <= '0;
            r_tail <= '0;
        end else if (i_cmd.skip) begin
            if (r_posmod != '0) begin
                r_pos <= r_pos + {{(AW-RW){1'b0}}, w_wrap - r_posmod};
            end
        end else if (i_cmd.emit) begin
            r_pos  <= w_pend;
            r_tail <= w_tail;
        end
    end

    // per item and per request working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_blk  <= i_in_data.target_block;
            r_left <= i_in_data.record_total;
            r_cnt  <= '0;
        end
        if (i_cmd.take_off) begin
            r_off <= r_mem_v ? r_mem_q : 16'd0;
        end
        if (i_cmd.mult) begin
            r_hb    <= PW'(r_off * w_rb);
            r_seek  <= {16'd0, r_blk} * {8'd0, r_rpb} + {8'd0, r_off};
            r_retry <= 1'b0;
        end
        if (i_cmd.mod_take) begin
            r_posmod <= w_div_r;
        end
        if (i_cmd.cap_take) begin
            r_cap <= w_div_q[RW-1:0];
        end
        if (i_cmd.cap_clear) begin
            r_cap <= '0;
        end
        if (i_cmd.skip) begin
            r_retry <= 1'b1;
        end
        if (i_cmd.cap_fix && (r_cap == '0)) begin
            r_cap <= RW'(1);
        end
        if (i_cmd.calc1) begin
            r_n      <= w_n;
            r_pstart <= w_bump ? r_pos + AW'(prp_pkg::PAGE_BYTES) : r_pos;
        end
        if (i_cmd.calc2) begin
            r_prod   <= r_n * w_rb;
            r_dstart <= r_pstart - {{(AW-PW){1'b0}}, w_head};
        end
        if (i_cmd.calc3) begin
            r_dend <= r_dstart + {{(AW-32){1'b0}}, r_prod};
        end
        if (i_cmd.emit) begin
            r_off  <= r_off + r_n;
            r_left <= w_left_nx;
            r_cnt  <= w_cnt_nx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.request_block   <= r_blk;
            r_out.seek_record     <= r_seek;
            r_out.request_records <= r_n;
            r_out.page_start      <= r_pstart;
            r_out.data_start      <= r_dstart;
            r_out.data_end        <= r_dend;
            r_out.page_end        <= w_pend;
            r_out.final_request   <= w_last;
            r_out.overflow        <= w_ovf;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign o_sts.div_done  = w_div_done;
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.room_pos  = w_room_pos;
    assign o_sts.cap_zero  = (r_cap == '0);
    assign o_sts.retried   = r_retry;
    assign o_sts.out_free  = !r_ovalid || !i_out_stall;
    assign o_sts.last      = w_last;

endmodule

FILE: rtl/prp_ctrl.sv
// ----------------------------------------------------------------------------
// prp_ctrl
// Sequencer: fetches each item's offset, then walks each request through
// ring modulo, fit division, placement and result transfer.
// ----------------------------------------------------------------------------
module prp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  prp_pkg::t_sts  i_sts,
    output prp_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_OFF   = 4'd2;
    localparam logic [3:0] S_MULT  = 4'd3;
    localparam logic [3:0] S_MOD   = 4'd4;
    localparam logic [3:0] S_MODW  = 4'd5;
    localparam logic [3:0] S_CAP   = 4'd6;
    localparam logic [3:0] S_CAPW  = 4'd7;
    localparam logic [3:0] S_DEC   = 4'd8;
    localparam logic [3:0] S_CALC1 = 4'd9;
    localparam logic [3:0] S_CALC2 = 4'd10;
    localparam logic [3:0] S_CALC3 = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.rd_mem = 1'b1;
                n_state      = i_sts.left_zero ? S_IDLE : S_OFF;
            end
            S_OFF: begin
                o_cmd.take_off = 1'b1;
                n_state        = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_start = 1'b1;
                n_state         = S_MODW;
            end
            S_MODW: begin
                if (i_sts.div_done) begin
                    o_cmd.mod_take = 1'b1;
                    n_state        = S_CAP;
                end
            end
            S_CAP: begin
                if (i_sts.room_pos) begin
                    o_cmd.cap_start = 1'b1;
                    n_state         = S_CAPW;
                end else begin
                    o_cmd.cap_clear = 1'b1;
                    n_state         = S_DEC;
                end
            end
            S_CAPW: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_take = 1'b1;
                    n_state        = S_DEC;
                end
            end
            S_DEC: begin
                // nothing fits: jump to the wrap boundary once, then force one record
                if (i_sts.cap_zero && !i_sts.retried) begin
                    o_cmd.skip = 1'b1;
                    n_state    = S_MOD;
                end else begin
                    o_cmd.cap_fix = 1'b1;
                    n_state       = S_CALC1;
                end
            end
            S_CALC1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_CALC2;
            end
            S_CALC2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_CALC3;
            end
            S_CALC3: begin
                o_cmd.calc3 = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.last ? S_IDLE : S_MULT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/paged_ring_read_request_planner.sv
// ----------------------------------------------------------------------------
// paged_ring_read_request_planner
// Splits a record count into page-aligned read requests in a ring buffer.
// ----------------------------------------------------------------------------
// One item is planned at a time. Each request uses the bit-serial divider
// twice (ring position modulo ring size, then fitting room over record
// size) plus placement steps; when no room is left before the wrap boundary
// the fitting division is skipped. A request that must skip to the wrap
// boundary repeats the modulo pass and the fitting division. An item runs a
// load and offset fetch setup, then up to 64 requests. A zero count
// produces no request.
// Restart clears the per-block offsets at once; there is no clearing pass.
// Results leave through an output register, so the next request is computed
// while the previous one waits to be taken.
module paged_ring_read_request_planner (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  prp_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output prp_pkg::t_out_item    o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    prp_pkg::t_cmd w_cmd;
    prp_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    prp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    prp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/prp_checker.sv
// ----------------------------------------------------------------------------
// prp_checker
// Port-level checks for the planner, bound to the top level.
// ----------------------------------------------------------------------------
module prp_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_stall,
    input  logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  prp_pkg::t_out_item    o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // one item at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    a_ovf_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |-> o_out_data.final_request)
        else $error("overflow without final");

    // page start may sit on an unaligned wrap boundary; page end never does
    a_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.page_end[prp_pkg::PAGE_W-1:0] == '0)
                     && (o_out_data.request_records != '0))
        else $error("misaligned or empty request");

endmodule

bind paged_ring_read_request_planner prp_checker u_prp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
